// ===== design/adjmx_pkg.sv =====
// ----------------------------------------------------------------------------
// adjmx_pkg
// Shared types and constants for the adjacency matrix store.
// ----------------------------------------------------------------------------
package adjmx_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = 6;
  localparam int ROW_W        = 2 ** VIDX_W;
  localparam int NUM_ROWS     = ROW_W;
  localparam int CNT_W        = VIDX_W + 1;
  localparam int VERT_LIMIT   = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t VERT_LIMIT_C = CNT_W'(VERT_LIMIT);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    FN_ADD_EDGE  = 2'd0,
    FN_LIST_SUCC = 2'd1,
    FN_LIST_PRED = 2'd2,
    FN_UNUSED    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_FLUSH,
    ST_RESP
  } state_t;

  // write request into the row store
  typedef struct packed {
    logic  en;
    vidx_t addr;
    row_t  data;
  } row_wr_t;

endpackage

// ===== design/adjacency_matrix_store.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_store
// Directed graph kept as a 64x64 edge bit matrix plus a vertex count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   add edge, list successors, or list predecessors of a vertex.
//   Output channel (out_valid/out_ready) returns result transfers. An add
//   edge gives one acknowledgement; a listing gives one transfer per
//   neighbor in ascending order with out_last on the final one, or a single
//   transfer without neighbor when none is found. Bad vertices and the
//   unused function code give a single transfer with out_status set.
//   One command is in flight at a time; in_ready is high only when idle.
//   Add edge reads the old row at acceptance, writes it back with the new
//   bit in ST_ADD and acknowledges from ST_RESP. A listing scans the indices
//   below the vertex count, one per cycle while not stalled (see Stall); the
//   scan loop, one memory row read per cycle for predecessors, sets its time.
//   Reset: synchronous, active low. Per-row valid bits clear the matrix at
//   reset; the vertex count returns to zero. No clearing pass.
//   Stall: a full output register holds the scan at an index that hits while
//   a neighbor is pending (the memory re-reads the same row) until out_ready frees it.
// ----------------------------------------------------------------------------
module adjacency_matrix_store
  import adjmx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_from_vertex,
  input  logic [5:0]  in_to_vertex,
  input  logic [5:0]  in_query_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_neighbour,
  output logic        out_has_neighbour,
  output logic        out_last,
  output logic        out_status,
  output logic [6:0]  out_vertex_count
);

  state_t state_r, state_nxt;

  // command registers
  func_t func_r, func_nxt;
  vidx_t from_r, from_nxt;
  vidx_t to_r, to_nxt;
  vidx_t q_r, q_nxt;
  logic  resp_err_r, resp_err_nxt;

  // graph size
  cnt_t count_r, count_nxt;

  // scan state: idx is the index whose row/bit the memory presents now
  vidx_t idx_r, idx_nxt;
  logic  pend_valid_r, pend_valid_nxt;
  vidx_t pend_idx_r, pend_idx_nxt;

  // output register
  logic  out_valid_r;
  vidx_t out_nb_r;
  logic  out_has_r;
  logic  out_last_r;
  logic  out_status_r;
  cnt_t  out_count_r;

  logic  out_free;
  logic  emit;
  vidx_t emit_nb;
  logic  emit_has;
  logic  emit_last;
  logic  emit_status;

  row_wr_t row_wr;
  vidx_t   rd_addr;
  row_t    rd_row;

  func_t in_func_e;
  cnt_t  in_max;
  logic  in_err;
  cnt_t  add_max;
  logic  hit;
  logic  at_last;
  logic  advance;

  adjmx_row_store u_rows (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (row_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  // ---- decode of an incoming command ----
  always_comb begin
    in_func_e = func_t'(in_func);
    in_max    = (in_from_vertex > in_to_vertex) ? CNT_W'(in_from_vertex)
                                                : CNT_W'(in_to_vertex);
    unique case (in_func_e)
      FN_ADD_EDGE:  in_err = (in_max >= VERT_LIMIT_C);
      FN_LIST_SUCC,
      FN_LIST_PRED: in_err = (CNT_W'(in_query_vertex) >= count_r);
      default:      in_err = 1'b1;
    endcase
  end

  // ---- scan step ----
  // successors: row q stays on the read port, test bit idx
  // predecessors: row idx comes from memory, test bit q
  always_comb begin
    hit     = (func_r == FN_LIST_SUCC) ? rd_row[idx_r] : rd_row[q_r];
    at_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    // a second hit needs the output register to take the pending one
    advance = !(hit && pend_valid_r && !out_free);
    add_max = (from_r > to_r) ? CNT_W'(from_r) : CNT_W'(to_r);
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_err) begin
            state_nxt = ST_RESP;
          end else if (in_func_e == FN_ADD_EDGE) begin
            state_nxt = ST_ADD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_ADD: begin
        state_nxt = ST_RESP;
      end
      ST_SCAN: begin
        if (advance && at_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH, ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- datapath and outputs ----
  always_comb begin
    func_nxt       = func_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    q_nxt          = q_r;
    resp_err_nxt   = resp_err_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    row_wr.en      = 1'b0;
    row_wr.addr    = from_r;
    row_wr.data    = rd_row | (ROW_W'(1) << to_r);
    rd_addr        = q_r;
    emit           = 1'b0;
    emit_nb        = '0;
    emit_has       = 1'b0;
    emit_last      = 1'b1;
    emit_status    = STATUS_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (in_func_e == FN_ADD_EDGE) begin
          rd_addr = in_from_vertex;
        end else if (in_func_e == FN_LIST_SUCC) begin
          rd_addr = in_query_vertex;
        end else begin
          rd_addr = '0;
        end
        if (in_valid) begin
          func_nxt       = in_func_e;
          from_nxt       = in_from_vertex;
          to_nxt         = in_to_vertex;
          q_nxt          = in_query_vertex;
          resp_err_nxt   = in_err;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      ST_ADD: begin
        // old row arrived from the read issued at acceptance
        row_wr.en = 1'b1;
        if ((add_max + CNT_W'(1)) > count_r) begin
          count_nxt = add_max + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        if (advance) begin
          idx_nxt = idx_r + VIDX_W'(1);
          if (hit) begin
            if (pend_valid_r) begin
              emit      = 1'b1;
              emit_nb   = pend_idx_r;
              emit_has  = 1'b1;
              emit_last = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = idx_r;
          end
        end
        rd_addr = (func_r == FN_LIST_SUCC) ? q_r : idx_nxt;
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_nb  = pend_valid_r ? pend_idx_r : '0;
          emit_has = pend_valid_r;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = resp_err_r ? STATUS_ERR : STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    q_r        <= q_nxt;
    resp_err_r <= resp_err_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (emit) begin
      out_nb_r     <= emit_nb;
      out_has_r    <= emit_has;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
      out_count_r  <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_neighbour     = out_nb_r;
  assign out_has_neighbour = out_has_r;
  assign out_last          = out_last_r;
  assign out_status        = out_status_r;
  assign out_vertex_count  = out_count_r;

endmodule

// ===== design/adjmx_row_store.sv =====
// ----------------------------------------------------------------------------
// adjmx_row_store
// Edge matrix memory, one row per source vertex, registered read port.
// ----------------------------------------------------------------------------
module adjmx_row_store
  import adjmx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  row_wr_t wr,
  input  vidx_t   rd_addr,
  output row_t    rd_data
);

  row_t mem [NUM_ROWS];
  logic row_valid_r [NUM_ROWS];
  row_t rd_mem_r;
  logic rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_mem_r <= mem[rd_addr];
  end

  // per-row valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        row_valid_r[i] <= 1'b0;
      end
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_mem_r : '0;

endmodule

// ===== design/adjmx_checker.sv =====
// ----------------------------------------------------------------------------
// adjmx_checker
// Port-level checks for the adjacency matrix store, bound to the top level.
// ----------------------------------------------------------------------------
module adjmx_checker
  import adjmx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic [5:0] in_from_vertex,
  input logic [5:0] in_to_vertex,
  input logic [5:0] in_query_vertex,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_neighbour,
  input logic       out_has_neighbour,
  input logic       out_last,
  input logic       out_status,
  input logic [6:0] out_vertex_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_neighbour)
      && $stable(out_has_neighbour) && $stable(out_last))
    else $error("result changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while busy");

  // found neighbor is never an error result
  a_nb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_neighbour |-> out_status == STATUS_OK)
    else $error("neighbor with error status");

  // result without neighbor always ends the command
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_neighbour |-> out_last)
    else $error("non-final result without neighbor");

  // vertex count never shrinks between results
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n)
      |-> out_vertex_count >= $past(out_vertex_count))
    else $error("vertex count decreased");

endmodule

bind adjacency_matrix_store adjmx_checker u_adjmx_checker (.*);
